### design/utj_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utj_pkg
// shared types, constants and helpers for the utf-8 to json escape block
// ----------------------------------------------------------------------------
package utj_pkg;

    localparam int NUM_SLOTS   = 5;                      // characters per byte, max
    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [7:0]        t_byte;
    typedef logic [6:0]        t_char;
    typedef logic [SLOT_W-1:0] t_slot;

    localparam t_char CH_BSL  = 7'h5C;                   // backslash
    localparam t_char CH_U    = 7'h75;                   // 'u'
    localparam t_char CH_D    = 7'h44;                   // 'D'
    localparam t_char CH_0    = 7'h30;                   // '0'
    localparam t_char CH_A10  = 7'h37;                   // 'A' - 10
    localparam t_char CH_ERR  = 7'h00;

    // characters caused by one input byte
    typedef struct packed {
        logic [NUM_SLOTS-1:0][6:0] chars;
        t_slot                     last_idx;
        logic                      bad;
    } t_burst;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic t_char hex_char(input logic [3:0] v);
        t_char r;
        if (v <= 4'd9) begin
            r = CH_0 + {3'b000, v};
        end else begin
            r = CH_A10 + {3'b000, v};
        end
        return r;
    endfunction

endpackage

### design/utj_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utj channel interfaces
// valid/ready channels for input bytes and output characters
// ----------------------------------------------------------------------------
interface utj_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface utj_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_char;
    logic       is_last;
    logic       bad_sequence;

    modport source (output valid, output out_char, output is_last,
                    output bad_sequence, input ready);
    modport sink   (input valid, input out_char, input is_last,
                    input bad_sequence, output ready);
endinterface

### design/utj_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utj_front
// decodes one utf-8 byte per cycle, while the queue is not full, into a burst of escape characters
// ----------------------------------------------------------------------------
module utj_front import utj_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utj_in_if.sink     i_in,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_burst     o_burst
);

    logic [1:0] r_rem, n_rem;
    t_byte      r_part, n_part;
    logic       r_surr, n_surr;

    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;

    always_comb begin
        t_byte      c;
        t_byte      p;
        logic [1:0] rem1;
        logic       fail;

        c     = i_in.in_byte;
        p     = '0;
        rem1  = r_rem - 2'd1;
        fail  = 1'b0;

        n_rem  = r_rem;
        n_part = r_part;
        n_surr = r_surr;

        o_burst          = '0;
        o_burst.last_idx = '0;

        if (c[7:6] == 2'b10) begin
            // continuation byte
            if (r_rem == 2'd0) begin
                fail = 1'b1;
            end else begin
                n_rem = rem1;
                case (rem1)
                    2'd0: begin
                        if (r_surr) begin
                            fail = 1'b1;
                        end else begin
                            p                = r_part | {2'b00, c[5:0]};
                            n_part           = p;
                            o_burst.chars[0] = hex_char(p[7:4]);
                            o_burst.chars[1] = hex_char(p[3:0]);
                            o_burst.last_idx = t_slot'(1);
                        end
                    end
                    2'd1: begin
                        if (r_surr) begin
                            // finish high surrogate, open the low one
                            p                = r_part | {2'b00, c[5:0]};
                            n_surr           = 1'b0;
                            o_burst.chars[0] = hex_char(p[7:4]);
                            o_burst.chars[1] = CH_BSL;
                            o_burst.chars[2] = CH_U;
                            o_burst.chars[3] = CH_D;
                            o_burst.chars[4] = hex_char({2'b11, p[3:2]});
                            o_burst.last_idx = t_slot'(4);
                        end else begin
                            o_burst.chars[0] = hex_char(c[5:2]);
                            o_burst.last_idx = t_slot'(0);
                        end
                        n_part = {c[1:0], 6'b000000};
                    end
                    default: begin
                        if (r_surr) begin
                            fail = 1'b1;
                        end else begin
                            // plane bits minus one for the high surrogate
                            p                = (r_part | {4'b0000, c[5:2]}) - 8'h04;
                            o_burst.chars[0] = hex_char({2'b10, p[5:4]});
                            o_burst.chars[1] = hex_char(p[3:0]);
                            o_burst.last_idx = t_slot'(1);
                            n_part           = {c[1:0], 6'b000000};
                            n_surr           = 1'b1;
                        end
                    end
                endcase
            end
        end else begin
            if (r_rem != 2'd0 || r_surr) begin
                fail = 1'b1;
            end else if (c[7] == 1'b0) begin
                o_burst.chars[0] = c[6:0];
                o_burst.last_idx = t_slot'(0);
            end else if (c[7:3] == 5'b11110) begin
                n_rem            = 2'd3;
                n_part           = {1'b0, c[2:0], 4'b0000};
                o_burst.chars[0] = CH_BSL;
                o_burst.chars[1] = CH_U;
                o_burst.chars[2] = CH_D;
                o_burst.last_idx = t_slot'(2);
            end else if (c[7:4] == 4'b1110) begin
                n_rem            = 2'd2;
                o_burst.chars[0] = CH_BSL;
                o_burst.chars[1] = CH_U;
                o_burst.chars[2] = hex_char(c[3:0]);
                o_burst.last_idx = t_slot'(2);
            end else if (c[7:5] == 3'b110) begin
                n_rem            = 2'd1;
                n_part           = {c[1:0], 6'b000000};
                o_burst.chars[0] = CH_BSL;
                o_burst.chars[1] = CH_U;
                o_burst.chars[2] = CH_0;
                o_burst.chars[3] = hex_char({1'b0, c[4:2]});
                o_burst.last_idx = t_slot'(3);
            end else begin
                fail = 1'b1;
            end
        end

        if (fail) begin
            n_rem            = '0;
            n_part           = '0;
            n_surr           = 1'b0;
            o_burst          = '0;
            o_burst.chars[0] = CH_ERR;
            o_burst.last_idx = t_slot'(0);
            o_burst.bad      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_part <= '0;
            r_surr <= 1'b0;
        end else if (o_push) begin
            r_rem  <= n_rem;
            r_part <= n_part;
            r_surr <= n_surr;
        end
    end

endmodule

### design/utj_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utj_queue
// short register queue of character bursts between front and back
// ----------------------------------------------------------------------------
module utj_queue import utj_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_burst    i_burst,
    input  logic      i_pop,
    output t_burst    o_head,
    output t_q_status o_status
);

    t_burst              r_entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head         = r_entries[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### design/utj_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utj_back
// serializes the head burst, one character per output transaction
// ----------------------------------------------------------------------------
module utj_back import utj_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_burst     i_head,
    input  t_q_status  i_q_status,
    output logic       o_pop,
    utj_out_if.source  o_out
);

    logic   r_valid;
    t_char  r_char;
    logic   r_last;
    logic   r_bad;
    t_slot  r_idx;

    logic   load;
    logic   at_last;

    assign load    = !i_q_status.empty && (!r_valid || o_out.ready);
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && at_last;

    assign o_out.valid        = r_valid;
    assign o_out.out_char     = r_char;
    assign o_out.is_last      = r_last;
    assign o_out.bad_sequence = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= at_last ? '0 : r_idx + 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_head.chars[r_idx];
            r_last <= at_last;
            r_bad  <= i_head.bad;
        end
    end

endmodule

### design/utf8_to_json_unicode_escape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_json_unicode_escape
// utf-8 byte stream to ascii with json \uXXXX escapes and surrogate pairs
// ----------------------------------------------------------------------------
//  channel   dir   payload                                handshake
//  i_in      in    in_byte[7:0]                           valid/ready
//  o_out     out   out_char[6:0], is_last, bad_sequence   valid/ready
//
//  a byte is decoded in the cycle it is taken; its 1 to 5 characters go
//  out one per cycle while the receiver is ready; ascii text runs at one
//  byte per cycle then, and the output register sets the pace
//  the two-entry burst queue lets input keep flowing while output stalls
//  synchronous active-low reset clears decoder state, queue and output valid
// ----------------------------------------------------------------------------
module utf8_to_json_unicode_escape import utj_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utj_in_if.sink     i_in,
    utj_out_if.source  o_out
);

    // front -> queue
    logic      push;
    t_burst    front_burst;

    // queue -> back
    logic      pop;
    t_burst    head_burst;
    t_q_status q_status;

    // decode: tracks continuation count, carried bits and surrogate flag
    utj_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_burst    (front_burst)
    );

    // decouples decode from output stalls
    utj_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_burst  (front_burst),
        .i_pop    (pop),
        .o_head   (head_burst),
        .o_status (q_status)
    );

    // one character per transaction, is_last on the final one of a burst
    utj_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_burst),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

### design/utj_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utj_checker
// port-level checks on the output channel of the escape block
// ----------------------------------------------------------------------------
module utj_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [6:0] i_out_char,
    input logic       i_out_last,
    input logic       i_out_bad
);

    // stalled transaction keeps valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    // stalled transaction keeps its payload
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_char) && $stable(i_out_last) && $stable(i_out_bad))
        else $error("output payload changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // an error is a single zero character closing its byte
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_bad |-> i_out_last && (i_out_char == 7'h00))
        else $error("malformed error result");

endmodule

bind utf8_to_json_unicode_escape utj_checker u_utj_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.out_char),
    .i_out_last  (o_out.is_last),
    .i_out_bad   (o_out.bad_sequence)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for utf8_to_json_unicode_escape
// feeds utf-8 byte streams (directed corner cases, then random well-formed
// and broken sequences) under several idle and stall patterns, predicts the
// escaped character stream per byte and checks every output transaction
// ----------------------------------------------------------------------------
module testbench;
    import utj_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int CYCLE_LIMIT  = 200000;     // far above the slowest correct run
    localparam int HOLD_CYCLES  = 300;        // long receiver hold-off
    localparam int TAIL_CYCLES  = 32;         // quiet time after the last character
    localparam int PHASE_BYTES  = 45;
    localparam int FILL_BYTES   = 20;

    // one expected output transaction
    typedef struct packed {
        t_char ch;
        logic  last;
        logic  bad;
    } t_escape_char;

    // escaped-stream predictor plus the queue of characters still owed
    class escape_scoreboard;
        t_escape_char owed_chars[$];
        logic [1:0]   cont_left;         // continuation bytes still expected
        t_byte        carry_bits;        // bits carried toward the next hex digit
        logic         high_half_open;    // high surrogate being finished
        int           errors;

        function new();
            cont_left      = 2'd0;
            carry_bits     = 8'h00;
            high_half_open = 1'b0;
            errors         = 0;
        endfunction

        function t_char hex_digit(input logic [3:0] v);
            t_char d;
            if (v < 4'd10) begin
                d = CH_0 + t_char'(v);
            end else begin
                d = CH_A10 + t_char'(v);
            end
            return d;
        endfunction

        // work out the characters caused by one accepted byte
        function void note_byte(input t_byte b);
            t_char        chars[$];
            logic         broken;
            t_escape_char e;
            broken = 1'b0;
            if (b[7:6] == 2'b10) begin
                if (cont_left == 2'd0) begin
                    broken = 1'b1;
                end else begin
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        if (high_half_open) begin
                            broken = 1'b1;
                        end else begin
                            carry_bits = carry_bits | {2'b00, b[5:0]};
                            chars.push_back(hex_digit(carry_bits[7:4]));
                            chars.push_back(hex_digit(carry_bits[3:0]));
                        end
                    end else if (cont_left == 2'd1) begin
                        if (high_half_open) begin
                            // close the high surrogate, open the low one
                            high_half_open = 1'b0;
                            carry_bits = carry_bits | {2'b00, b[5:0]};
                            chars.push_back(hex_digit(carry_bits[7:4]));
                            chars.push_back(CH_BSL);
                            chars.push_back(CH_U);
                            chars.push_back(CH_D);
                            chars.push_back(hex_digit({2'b11, carry_bits[3:2]}));
                        end else begin
                            chars.push_back(hex_digit(b[5:2]));
                        end
                        carry_bits = {b[1:0], 6'b000000};
                    end else begin
                        if (high_half_open) begin
                            broken = 1'b1;
                        end else begin
                            // plane minus one, wraps within the byte
                            carry_bits = (carry_bits | {4'b0000, b[5:2]}) - 8'd4;
                            chars.push_back(hex_digit({2'b10, carry_bits[5:4]}));
                            chars.push_back(hex_digit(carry_bits[3:0]));
                            carry_bits = {b[1:0], 6'b000000};
                            high_half_open = 1'b1;
                        end
                    end
                end
            end else if (cont_left != 2'd0 || high_half_open) begin
                broken = 1'b1;
            end else if (!b[7]) begin
                chars.push_back(b[6:0]);
            end else if (b[7:3] == 5'b11110) begin
                cont_left = 2'd3;
                chars.push_back(CH_BSL);
                chars.push_back(CH_U);
                chars.push_back(CH_D);
                carry_bits = {1'b0, b[2:0], 4'b0000};
            end else if (b[7:4] == 4'b1110) begin
                cont_left = 2'd2;
                chars.push_back(CH_BSL);
                chars.push_back(CH_U);
                chars.push_back(hex_digit(b[3:0]));
            end else if (b[7:5] == 3'b110) begin
                cont_left = 2'd1;
                carry_bits = {b[1:0], 6'b000000};
                chars.push_back(CH_BSL);
                chars.push_back(CH_U);
                chars.push_back(CH_0);
                chars.push_back(hex_digit({1'b0, b[4:2]}));
            end else begin
                broken = 1'b1;
            end

            if (broken) begin
                cont_left      = 2'd0;
                carry_bits     = 8'h00;
                high_half_open = 1'b0;
                e.ch   = CH_ERR;
                e.last = 1'b1;
                e.bad  = 1'b1;
                owed_chars.push_back(e);
            end else begin
                foreach (chars[i]) begin
                    e.ch   = chars[i];
                    e.last = (i == chars.size() - 1);
                    e.bad  = 1'b0;
                    owed_chars.push_back(e);
                end
            end
        endfunction

        // compare one output transaction with the oldest owed character
        function void check_char(input t_char ch, input logic last, input logic bad);
            t_escape_char e;
            if (owed_chars.size() == 0) begin
                $display("%0t: unexpected character: expected none, got %s %h %s %b %s %b",
                         $time, "out_char", ch, "is_last", last, "bad", bad);
                errors++;
            end else begin
                e = owed_chars.pop_front();
                if (ch !== e.ch) begin
                    $display("%0t: out_char mismatch: expected %h, got %h",
                             $time, e.ch, ch);
                    errors++;
                end
                if (last !== e.last) begin
                    $display("%0t: is_last mismatch: expected %b, got %b",
                             $time, e.last, last);
                    errors++;
                end
                if (bad !== e.bad) begin
                    $display("%0t: bad_sequence mismatch: expected %b, got %b",
                             $time, e.bad, bad);
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    utj_in_if  in_ch ();
    utj_out_if out_ch ();

    utf8_to_json_unicode_escape dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    escape_scoreboard board = new();

    int   send_idle_pct;      // chance the sender sits out a cycle
    int   recv_stall_pct;     // chance the receiver drops ready
    bit   hold_request;       // asks the receiver for a long hold-off
    int   cycle_count;

    // directed bytes: ascii extremes, every lead length with edge code
    // points, then a stray continuation, illegal leads, a lead cut short
    // by ascii and an overlong two-byte form
    t_byte directed_bytes[$] = {
        8'h00, 8'h7F,
        8'hC2, 8'hA9,
        8'hD0, 8'h80,                    // first code point needing the third lead bit
        8'hDF, 8'hBF,
        8'hEF, 8'hBF, 8'hBF,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'h80,                           // continuation with nothing open
        8'hF8, 8'hFF,                    // leads that are never legal
        8'hC3, 8'h41,                    // new character inside a sequence
        8'hC0, 8'hAF                     // overlong, escaped as decoded
    };

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** utf8_to_json_unicode_escape: FAILED **");
        $finish;
    end

    // receiver: checks each output transaction, stalls at random, and does
    // one long hold-off on request so the block backs up into its input
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) begin
                board.check_char(out_ch.out_char, out_ch.is_last, out_ch.bad_sequence);
            end
            if (hold_request) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one byte, idling first at random, and wait for the transaction
    task automatic send_byte(input t_byte b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do @(posedge clk); while (!in_ch.ready);
        board.note_byte(b);
    endtask

    function automatic t_byte lead_byte(input int len);
        t_byte b;
        case (len)
            2:       b = 8'hC0 | t_byte'($urandom_range(31));
            3:       b = 8'hE0 | t_byte'($urandom_range(15));
            default: b = 8'hF0 | t_byte'($urandom_range(7));
        endcase
        return b;
    endfunction

    function automatic t_byte cont_byte();
        return 8'h80 | t_byte'($urandom_range(63));
    endfunction

    // mostly complete sequences with random content, plus ascii bytes, some
    // noise bytes and some sequences cut short
    task automatic send_random_run(input int n_bytes);
        int sent;
        int pick;
        int len;
        int keep;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_byte(t_byte'($urandom_range(127)));
                sent++;
            end else if (pick < 88) begin
                len = (pick < 50) ? 2 : (pick < 70) ? 3 : 4;
                send_byte(lead_byte(len));
                sent++;
                for (int k = 1; k < len; k++) begin
                    send_byte(cont_byte());
                    sent++;
                end
            end else if (pick < 94) begin
                send_byte(t_byte'($urandom_range(255)));
                sent++;
            end else begin
                len  = $urandom_range(2, 4);
                keep = $urandom_range(0, len - 2);
                send_byte(lead_byte(len));
                sent++;
                for (int k = 0; k < keep; k++) begin
                    send_byte(cont_byte());
                    sent++;
                end
            end
        end
    endtask

    // sender stops and waits until every owed character has come out
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.owed_chars.size() != 0) @(posedge clk);
    endtask

    initial begin
        int idle_table  [4] = '{0, 58, 0, 15};
        int stall_table [4] = '{0, 0, 58, 15};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b0;
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_bytes[i]) begin
            send_byte(directed_bytes[i]);
        end
        wait_drain();

        // idle phases: none, sender only, receiver only, both
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_table[p];
            recv_stall_pct = stall_table[p];
            send_random_run(PHASE_BYTES);
            wait_drain();
        end

        // back-pressure: receiver holds off while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 15;
        hold_request   = 1'b1;
        send_random_run(FILL_BYTES);
        wait_drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0) begin
            $display("** utf8_to_json_unicode_escape: PASSED **");
        end else begin
            $display("** utf8_to_json_unicode_escape: FAILED **");
        end
        $finish;
    end

endmodule
